/* sv/spe_pkg.sv */
// Shared types, constants and register codes of the step pair energy unit.
`timescale 1ns / 1ps

package spe_pkg;

  // Default sizing, handed to the top level parameters
  localparam int MAX_STEPS_DEF = 4;
  localparam int NUM_TYPES_DEF = 32;

  // Fixed field widths
  localparam int LIMIT_REGS = 4;
  localparam int COORD_W    = 20;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int SQ_W       = 2 * COORD_W;
  localparam int DSQ_W      = SQ_W + 2;
  localparam int TYPE_W     = 6;
  localparam int STEP_W     = 2;
  localparam int ENERGY_W   = 32;
  localparam int SUM_W      = 48;
  localparam int COUNT_W    = 32;
  localparam int ACT_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = DSQ_W;
  localparam int Q_DEPTH    = 4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_STEPS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_0      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_1      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_2      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_3      = 3'd4;

  // Item operation codes
  localparam logic OP_PAIR        = 1'b0;
  localparam logic OP_TABLE_WRITE = 1'b1;

  // Saturation limits of the running sum
  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef struct packed {
    logic                       op;
    logic signed [COORD_W-1:0]  rec_x;
    logic signed [COORD_W-1:0]  rec_y;
    logic signed [COORD_W-1:0]  rec_z;
    logic signed [COORD_W-1:0]  lig_x;
    logic signed [COORD_W-1:0]  lig_y;
    logic signed [COORD_W-1:0]  lig_z;
    logic [TYPE_W-1:0]          rec_type;
    logic [TYPE_W-1:0]          lig_type;
    logic [STEP_W-1:0]          step_index;
    logic signed [ENERGY_W-1:0] energy_word;
    logic                       last_pair;
  } spe_in_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] total_energy;
    logic [COUNT_W-1:0]      pairs_summed;
    logic                    saturated;
  } spe_out_t;

  typedef struct packed {
    logic [ACT_W-1:0]                   active_steps;
    logic [LIMIT_REGS-1:0][DSQ_W-1:0]   limit_sq;
  } spe_cfg_t;

  // Classified item passed from the front to the back through the queue
  typedef struct packed {
    logic                       is_pair;
    logic                       wr_ok;
    logic                       hit;
    logic [STEP_W-1:0]          step;
    logic [TYPE_W-1:0]          rec_type;
    logic [TYPE_W-1:0]          lig_type;
    logic signed [ENERGY_W-1:0] energy_word;
    logic                       last_pair;
  } spe_cmd_t;

endpackage

/* sv/spe_front.sv */
// Front pipeline: coordinate differences, squares, distance sum and step selection.
`timescale 1ns / 1ps

module spe_front #(
  parameter int MAX_STEPS = spe_pkg::MAX_STEPS_DEF,
  parameter int NUM_TYPES = spe_pkg::NUM_TYPES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  spe_pkg::spe_in_t  in_item,
  input  spe_pkg::spe_cfg_t cfg,
  input  logic              q_full,
  output logic              q_push,
  output spe_pkg::spe_cmd_t q_cmd
);

  localparam int N_LIM = (MAX_STEPS < spe_pkg::LIMIT_REGS) ? MAX_STEPS : spe_pkg::LIMIT_REGS;
  localparam int TYPE_CMP_W = spe_pkg::TYPE_W + 1;
  localparam int STEP_CMP_W = spe_pkg::STEP_W + 2;
  localparam logic [TYPE_CMP_W-1:0] NT_CMP = TYPE_CMP_W'(NUM_TYPES);
  localparam logic [STEP_CMP_W-1:0] MS_CMP = STEP_CMP_W'(MAX_STEPS);
  localparam logic [spe_pkg::ACT_W-1:0] N_LIM_C = spe_pkg::ACT_W'(N_LIM);

  typedef struct packed {
    spe_pkg::spe_in_t                   item;
    logic signed [spe_pkg::DIFF_W-1:0]  dx;
    logic signed [spe_pkg::DIFF_W-1:0]  dy;
    logic signed [spe_pkg::DIFF_W-1:0]  dz;
  } s1_t;

  typedef struct packed {
    spe_pkg::spe_in_t              item;
    logic [2:0][spe_pkg::SQ_W-1:0] sq;
  } s2_t;

  typedef struct packed {
    spe_pkg::spe_in_t           item;
    logic [spe_pkg::DSQ_W-1:0]  dsq;
  } s3_t;

  logic s1_v_r, s1_v_nxt, s2_v_r, s2_v_nxt, s3_v_r, s3_v_nxt, s4_v_r, s4_v_nxt;
  logic s1_rdy, s2_rdy, s3_rdy, s4_rdy;
  s1_t  s1_r, s1_nxt;
  s2_t  s2_r, s2_nxt;
  s3_t  s3_r, s3_nxt;
  spe_pkg::spe_cmd_t s4_r, s4_nxt;

  logic signed [2*spe_pkg::DIFF_W-1:0] px, py, pz;
  logic [spe_pkg::ACT_W-1:0]  n_steps;
  logic                       rt_ok, lt_ok, step_ok, hit;
  logic [spe_pkg::STEP_W-1:0] sel;

  function automatic logic type_ok(input logic [spe_pkg::TYPE_W-1:0] t);
    return (t != '0) && ({1'b0, t} <= NT_CMP);
  endfunction

  // Each stage moves when the one after it is empty or moving
  assign s4_rdy   = !s4_v_r || !q_full;
  assign s3_rdy   = !s3_v_r || s4_rdy;
  assign s2_rdy   = !s2_v_r || s3_rdy;
  assign s1_rdy   = !s1_v_r || s2_rdy;
  assign in_stall = !s1_rdy;
  assign q_push   = s4_v_r && !q_full;
  assign q_cmd    = s4_r;

  assign s1_v_nxt = s1_rdy ? in_valid : s1_v_r;
  assign s2_v_nxt = s2_rdy ? s1_v_r   : s2_v_r;
  assign s3_v_nxt = s3_rdy ? s2_v_r   : s3_v_r;
  assign s4_v_nxt = s4_rdy ? s3_v_r   : s4_v_r;

  always_comb begin
    s1_nxt.item = in_item;
    s1_nxt.dx   = spe_pkg::DIFF_W'(in_item.rec_x) - spe_pkg::DIFF_W'(in_item.lig_x);
    s1_nxt.dy   = spe_pkg::DIFF_W'(in_item.rec_y) - spe_pkg::DIFF_W'(in_item.lig_y);
    s1_nxt.dz   = spe_pkg::DIFF_W'(in_item.rec_z) - spe_pkg::DIFF_W'(in_item.lig_z);
  end

  always_comb begin
    px = s1_r.dx * s1_r.dx;
    py = s1_r.dy * s1_r.dy;
    pz = s1_r.dz * s1_r.dz;
    s2_nxt.item  = s1_r.item;
    s2_nxt.sq[0] = px[spe_pkg::SQ_W-1:0];
    s2_nxt.sq[1] = py[spe_pkg::SQ_W-1:0];
    s2_nxt.sq[2] = pz[spe_pkg::SQ_W-1:0];
  end

  always_comb begin
    s3_nxt.item = s2_r.item;
    s3_nxt.dsq  = spe_pkg::DSQ_W'(s2_r.sq[0]) + spe_pkg::DSQ_W'(s2_r.sq[1])
                + spe_pkg::DSQ_W'(s2_r.sq[2]);
  end

  // Pick the first active step whose limit lies above the distance
  always_comb begin
    n_steps = (cfg.active_steps > N_LIM_C) ? N_LIM_C : cfg.active_steps;
    rt_ok   = type_ok(s3_r.item.rec_type);
    lt_ok   = type_ok(s3_r.item.lig_type);
    step_ok = {2'b00, s3_r.item.step_index} < MS_CMP;
    hit     = 1'b0;
    sel     = '0;
    for (int i = spe_pkg::LIMIT_REGS - 1; i >= 0; i--) begin
      if ((spe_pkg::ACT_W'(i) < n_steps) && (s3_r.dsq < cfg.limit_sq[i])) begin
        hit = 1'b1;
        sel = spe_pkg::STEP_W'(i);
      end
    end
    s4_nxt.is_pair     = (s3_r.item.op == spe_pkg::OP_PAIR);
    s4_nxt.wr_ok       = (s3_r.item.op == spe_pkg::OP_TABLE_WRITE) && step_ok && rt_ok && lt_ok;
    s4_nxt.hit         = (s3_r.item.op == spe_pkg::OP_PAIR) && hit && rt_ok && lt_ok;
    s4_nxt.step        = (s3_r.item.op == spe_pkg::OP_PAIR) ? sel : s3_r.item.step_index;
    s4_nxt.rec_type    = s3_r.item.rec_type;
    s4_nxt.lig_type    = s3_r.item.lig_type;
    s4_nxt.energy_word = s3_r.item.energy_word;
    s4_nxt.last_pair   = s3_r.item.last_pair;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
      s3_v_r <= s3_v_nxt;
      s4_v_r <= s4_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy && in_valid) begin
      s1_r <= s1_nxt;
    end
    if (s2_rdy && s1_v_r) begin
      s2_r <= s2_nxt;
    end
    if (s3_rdy && s2_v_r) begin
      s3_r <= s3_nxt;
    end
    if (s4_rdy && s3_v_r) begin
      s4_r <= s4_nxt;
    end
  end

`ifndef ASSERT_OFF
  // Input stalls only with every stage occupied and the queue full
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_v_r && s2_v_r && s3_v_r && s4_v_r && q_full))
    else $error("front stalled with room in the pipeline");
`endif

endmodule

/* sv/spe_queue.sv */
// Short queue of classified items between the front and the back.
`timescale 1ns / 1ps

module spe_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  spe_pkg::spe_cmd_t push_cmd,
  output logic              full,
  input  logic              pop,
  output logic              avail,
  output spe_pkg::spe_cmd_t head
);

  localparam int PTR_W = $clog2(spe_pkg::Q_DEPTH);
  localparam int CNT_W = PTR_W + 1;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(spe_pkg::Q_DEPTH);
  localparam logic [PTR_W-1:0] LAST_C  = PTR_W'(spe_pkg::Q_DEPTH - 1);

  spe_pkg::spe_cmd_t entry_r [spe_pkg::Q_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign full  = (count_r == DEPTH_C);
  assign avail = (count_r != '0);
  assign head  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_C) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_C) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r <= DEPTH_C) && !(pop && !avail))
    else $error("queue count out of range or popped while empty");
`endif

endmodule

/* sv/spe_back.sv */
// Back end: energy table, saturating accumulator and result register.
`timescale 1ns / 1ps

module spe_back #(
  parameter int MAX_STEPS = spe_pkg::MAX_STEPS_DEF,
  parameter int NUM_TYPES = spe_pkg::NUM_TYPES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_avail,
  input  spe_pkg::spe_cmd_t q_head,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output spe_pkg::spe_out_t out_item
);

  localparam int DEPTH  = MAX_STEPS * NUM_TYPES * NUM_TYPES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int EXT_W  = spe_pkg::SUM_W + 1 - spe_pkg::ENERGY_W;

  logic [spe_pkg::ENERGY_W-1:0] mem [DEPTH];
  logic [spe_pkg::ENERGY_W-1:0] rd_r;
  logic [ADDR_W-1:0]            head_addr;

  logic              b1_v_r, b1_v_nxt, b1_go;
  spe_pkg::spe_cmd_t b1_cmd_r;

  logic signed [spe_pkg::SUM_W-1:0] sum_r, sum_nxt, s_sat;
  logic [spe_pkg::COUNT_W-1:0]      cnt_r, cnt_nxt, cnt_inc;
  logic                             clip_r, clip_nxt, ovf;
  logic signed [spe_pkg::SUM_W:0]   e_ext, s_wide;
  logic                             acc, emit;

  logic              out_v_r, out_v_nxt;
  spe_pkg::spe_out_t out_r;

  assign head_addr = ADDR_W'((int'(q_head.step) * NUM_TYPES + int'(q_head.rec_type) - 1)
                             * NUM_TYPES + int'(q_head.lig_type) - 1);

  // A last pair blocks only while the previous result still waits
  assign b1_go    = !b1_v_r || !(b1_cmd_r.is_pair && b1_cmd_r.last_pair && out_v_r && out_stall);
  assign q_pop    = q_avail && b1_go;
  assign b1_v_nxt = b1_go ? q_avail : b1_v_r;

  assign acc  = b1_v_r && b1_go && b1_cmd_r.is_pair;
  assign emit = acc && b1_cmd_r.last_pair;

  always_comb begin
    e_ext   = b1_cmd_r.hit ? {{EXT_W{rd_r[spe_pkg::ENERGY_W-1]}}, rd_r} : '0;
    s_wide  = {sum_r[spe_pkg::SUM_W-1], sum_r} + e_ext;
    ovf     = s_wide[spe_pkg::SUM_W] != s_wide[spe_pkg::SUM_W-1];
    s_sat   = ovf ? (s_wide[spe_pkg::SUM_W] ? spe_pkg::SUM_MIN : spe_pkg::SUM_MAX)
                  : s_wide[spe_pkg::SUM_W-1:0];
    cnt_inc = (cnt_r == '1) ? cnt_r : cnt_r + 1'b1;
    sum_nxt  = sum_r;
    cnt_nxt  = cnt_r;
    clip_nxt = clip_r;
    if (emit) begin
      sum_nxt  = '0;
      cnt_nxt  = '0;
      clip_nxt = 1'b0;
    end else if (acc) begin
      sum_nxt  = s_sat;
      cnt_nxt  = cnt_inc;
      clip_nxt = clip_r | ovf;
    end
    out_v_nxt = emit ? 1'b1 : (out_stall ? out_v_r : 1'b0);
  end

  assign out_valid = out_v_r;
  assign out_item  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r  <= 1'b0;
      sum_r   <= '0;
      cnt_r   <= '0;
      clip_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      b1_v_r  <= b1_v_nxt;
      sum_r   <= sum_nxt;
      cnt_r   <= cnt_nxt;
      clip_r  <= clip_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b1_cmd_r <= q_head;
    end
    if (emit) begin
      out_r.total_energy <= s_sat;
      out_r.pairs_summed <= cnt_inc;
      out_r.saturated    <= clip_r | ovf;
    end
  end

  // At most one table access per popped item: a write for a valid table item, a read for a hit
  always_ff @(posedge clk) begin
    if (q_pop && !q_head.is_pair && q_head.wr_ok) begin
      mem[head_addr] <= q_head.energy_word;
    end
    if (q_pop && q_head.is_pair && q_head.hit) begin
      rd_r <= mem[head_addr];
    end
  end

`ifndef ASSERT_OFF
  a_clear_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (sum_r == '0 && cnt_r == '0 && !clip_r))
    else $error("sum not cleared after result");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> $past(emit))
    else $error("result raised without a last pair");

  a_hold_read: assert property (@(posedge clk) disable iff (!rst_n)
    (b1_v_r && !b1_go) |=> (b1_v_r && $stable(rd_r)))
    else $error("blocked pair lost its table data");
`endif

endmodule

/* sv/step_potential_pair_energy_unit.sv */
// Top level of the step pair energy unit: configuration registers and the front, queue, back.
`timescale 1ns / 1ps

// Use:
//   in_*  : one item per accepted edge (in_valid high, in_stall low). An item
//           either writes one energy table entry or carries one atom pair.
//   out_* : one result per list, shown after the pair marked last_pair;
//           taken at an edge with out_valid high and out_stall low.
//   cfg_* : register writes, always ready; write only while the unit is idle.
// Throughput: one item per clock, with no bubbles, whatever the item mix, while the receiver holds no result back.
// Path: a last pair passes four front stages (differences, squares, distance
//   sum, step select), one queue slot and the table read register, and its
//   result then shows in the output register; the table read port sets the read register.
// Receiver stall: the result holds in the output register; further items
//   keep flowing until the next last pair reaches the accumulator, then the
//   four-entry queue and the front fill and in_stall rises.
// Reset: clears the sum, pair count, flag, registers and every valid bit;
//   the energy table keeps no reset and must be written before it is read.
module step_potential_pair_energy_unit #(
  parameter int MAX_STEPS = spe_pkg::MAX_STEPS_DEF,
  parameter int NUM_TYPES = spe_pkg::NUM_TYPES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  spe_pkg::spe_in_t                 in_item,
  output logic                             out_valid,
  input  logic                             out_stall,
  output spe_pkg::spe_out_t                out_item,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [spe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [spe_pkg::CFG_DATA_W-1:0]   cfg_data
);

  spe_pkg::spe_cfg_t cfg_r, cfg_nxt;

  logic              q_push, q_full, q_pop, q_avail;
  spe_pkg::spe_cmd_t q_cmd, q_head;

  // Registers accept a write every cycle
  assign cfg_ready = 1'b1;

  // Decode the register index; indexes past the list are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        spe_pkg::REG_ACTIVE_STEPS: cfg_nxt.active_steps = cfg_data[spe_pkg::ACT_W-1:0];
        spe_pkg::REG_LIMIT_0:      cfg_nxt.limit_sq[0]  = cfg_data;
        spe_pkg::REG_LIMIT_1:      cfg_nxt.limit_sq[1]  = cfg_data;
        spe_pkg::REG_LIMIT_2:      cfg_nxt.limit_sq[2]  = cfg_data;
        spe_pkg::REG_LIMIT_3:      cfg_nxt.limit_sq[3]  = cfg_data;
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front: classify each item against the step limits
  spe_front #(
    .MAX_STEPS (MAX_STEPS),
    .NUM_TYPES (NUM_TYPES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .cfg      (cfg_r),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  // Decouple the front from the table and accumulator
  spe_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .avail    (q_avail),
    .head     (q_head)
  );

  // Back: table access, saturating sum, result register
  spe_back #(
    .MAX_STEPS (MAX_STEPS),
    .NUM_TYPES (NUM_TYPES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_avail   (q_avail),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

/* test/spe_energy_tracker_pkg.sv */
// Expected-sum tracker for the step pair energy unit: register copy, energy table, list sums.
`timescale 1ns / 1ps

package spe_energy_tracker_pkg;
  import spe_pkg::*;

  localparam int TYPES   = NUM_TYPES_DEF;
  localparam int STEPS   = MAX_STEPS_DEF;
  localparam int ENTRIES = STEPS * TYPES * TYPES;

  class energy_sum_tracker;
    logic [ACT_W-1:0]           steps_reg;
    logic [DSQ_W-1:0]           limit_reg [LIMIT_REGS];
    logic signed [ENERGY_W-1:0] energy_tbl [ENTRIES];
    bit                         written [ENTRIES];
    longint                     run_sum;
    logic [COUNT_W-1:0]         run_count;
    bit                         run_clipped;
    spe_out_t                   pending_sums [$];
    int                         errors;

    function new();
      steps_reg = '0;
      foreach (limit_reg[i]) limit_reg[i] = '0;
      foreach (written[i]) written[i] = 1'b0;
      run_sum     = 0;
      run_count   = '0;
      run_clipped = 1'b0;
      errors      = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_ACTIVE_STEPS: steps_reg = val[ACT_W-1:0];
        REG_LIMIT_0:      limit_reg[0] = val;
        REG_LIMIT_1:      limit_reg[1] = val;
        REG_LIMIT_2:      limit_reg[2] = val;
        REG_LIMIT_3:      limit_reg[3] = val;
        default: ;
      endcase
    endfunction

    function bit type_ok(logic [TYPE_W-1:0] t);
      return int'(t) >= 1 && int'(t) <= TYPES;
    endfunction

    function int entry_addr(int step, logic [TYPE_W-1:0] rt, logic [TYPE_W-1:0] lt);
      return (step * TYPES + int'(rt) - 1) * TYPES + int'(lt) - 1;
    endfunction

    // Step whose table entry the pair reads, or -1 when it adds nothing
    function int hit_step(spe_in_t it);
      longint dx, dy, dz, dsq;
      int     n, i;
      if (!type_ok(it.rec_type) || !type_ok(it.lig_type)) return -1;
      dx  = longint'($signed(it.rec_x)) - longint'($signed(it.lig_x));
      dy  = longint'($signed(it.rec_y)) - longint'($signed(it.lig_y));
      dz  = longint'($signed(it.rec_z)) - longint'($signed(it.lig_z));
      dsq = dx * dx + dy * dy + dz * dz;
      n   = int'(steps_reg);
      if (n > STEPS) n = STEPS;
      if (n > LIMIT_REGS) n = LIMIT_REGS;
      for (i = 0; i < n; i++) begin
        if (dsq < longint'(limit_reg[i])) return i;
      end
      return -1;
    endfunction

    function void take_item(spe_in_t it);
      int       step, a;
      longint   e, s;
      spe_out_t sum_out;
      if (it.op == OP_TABLE_WRITE) begin
        if (type_ok(it.rec_type) && type_ok(it.lig_type) && int'(it.step_index) < STEPS) begin
          a = entry_addr(int'(it.step_index), it.rec_type, it.lig_type);
          energy_tbl[a] = it.energy_word;
          written[a]    = 1'b1;
        end
        return;
      end
      step = hit_step(it);
      e    = 0;
      if (step >= 0) e = longint'(energy_tbl[entry_addr(step, it.rec_type, it.lig_type)]);
      s = run_sum + e;
      if (s > longint'(SUM_MAX)) begin
        s = longint'(SUM_MAX);
        run_clipped = 1'b1;
      end
      if (s < longint'(SUM_MIN)) begin
        s = longint'(SUM_MIN);
        run_clipped = 1'b1;
      end
      run_sum = s;
      if (run_count != '1) run_count++;
      if (it.last_pair) begin
        sum_out.total_energy = SUM_W'(run_sum);
        sum_out.pairs_summed = run_count;
        sum_out.saturated    = run_clipped;
        pending_sums.push_back(sum_out);
        run_sum     = 0;
        run_count   = '0;
        run_clipped = 1'b0;
      end
    endfunction

    function void match_sum(spe_out_t got);
      spe_out_t want;
      if (pending_sums.size() == 0) begin
        $error("unexpected result: total_energy %0d pairs_summed %0d",
               got.total_energy, got.pairs_summed);
        errors++;
        return;
      end
      want = pending_sums.pop_front();
      if (got.total_energy !== want.total_energy) begin
        $error("total_energy: expected %0d, actual %0d", want.total_energy, got.total_energy);
        errors++;
      end
      if (got.pairs_summed !== want.pairs_summed) begin
        $error("pairs_summed: expected %0d, actual %0d", want.pairs_summed, got.pairs_summed);
        errors++;
      end
      if (got.saturated !== want.saturated) begin
        $error("saturated: expected %0b, actual %0b", want.saturated, got.saturated);
        errors++;
      end
    endfunction

    function int pending();
      return pending_sums.size();
    endfunction
  endclass

endpackage

/* test/testbench.sv */
// Testbench of the step pair energy unit: directed lists, large-sum runs, random phases.
`timescale 1ns / 1ps

module testbench;
  import spe_pkg::*;
  import spe_energy_tracker_pkg::*;

  localparam int NT           = NUM_TYPES_DEF;
  localparam int SETTLE       = 12;      // lets the pipeline drain, with margin
  localparam int HOLD_CYCLES  = 400;     // long receiver hold-off to back the unit up
  localparam int PHASE_ITEMS  = 140;
  localparam int BIG_PAIRS    = 60;      // full-scale energies, sum well past 32 bits
  localparam int REACH        = 14000;   // per-axis offset of a near pair, Q9.10
  localparam int CYCLE_LIMIT  = 1500000;

  localparam logic signed [COORD_W-1:0]  COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0]  COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic signed [ENERGY_W-1:0] E_MAX     = {1'b0, {(ENERGY_W-1){1'b1}}};
  localparam logic signed [ENERGY_W-1:0] E_MIN     = {1'b1, {(ENERGY_W-1){1'b0}}};
  localparam logic signed [ENERGY_W-1:0] E_NEG1    = '1;
  localparam logic [CFG_DATA_W-1:0]      LIMIT_TOP = '1;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  spe_in_t               in_item   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  spe_out_t              out_item;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // calm: neither side idles; hold_req: ask the receiver for one long hold-off
  bit                    calm      = 1'b0;
  bit                    hold_req  = 1'b0;
  bit                    hold_done = 1'b0;
  int                    hold_left = 0;
  int                    cycle_count = 0;

  energy_sum_tracker     tracker;

  step_potential_pair_energy_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // Guard against a hung run: missing results or a stuck stall end here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Receiver: check each result taken, then pick next cycle's stall. A pending
  // hold request turns into one long stretch of stall, counted down here, so
  // the queue and front of the unit fill and in_stall has to rise.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) tracker.match_sum(out_item);
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (hold_req && !hold_done) begin
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 26);
      end
    end
  end

  // Fully random item: every field, used or not, gets fresh bits
  function automatic spe_in_t any_item();
    logic [191:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return spe_in_t'(raw[$bits(spe_in_t)-1:0]);
  endfunction

  function automatic int spread(int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  function automatic logic signed [COORD_W-1:0] rail_coord();
    return ($urandom_range(1) != 0) ? COORD_MAX : COORD_MIN;
  endfunction

  // Squared radius in Angstroms as a Q20 limit
  function automatic logic [CFG_DATA_W-1:0] sq_radius(int r);
    return CFG_DATA_W'(longint'(r) * longint'(r) * 64'd1048576);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] any_limit();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[CFG_DATA_W-1:0];
  endfunction

  // Item with chosen codes; the ligand sits dx along x from a random receptor
  function automatic spe_in_t shaped_item(logic op, int rt, int lt, int step,
                                          logic signed [ENERGY_W-1:0] energy,
                                          int dx, logic last);
    spe_in_t it;
    it             = any_item();
    it.op          = op;
    it.rec_type    = TYPE_W'(rt);
    it.lig_type    = TYPE_W'(lt);
    it.step_index  = STEP_W'(step);
    it.energy_word = energy;
    it.last_pair   = last;
    it.rec_x       = COORD_W'(spread(500000));
    it.rec_y       = COORD_W'(spread(500000));
    it.rec_z       = COORD_W'(spread(500000));
    it.lig_x       = it.rec_x + COORD_W'(dx);
    it.lig_y       = it.rec_y;
    it.lig_z       = it.rec_z;
    return it;
  endfunction

  function automatic spe_in_t random_write();
    spe_in_t it;
    it    = any_item();
    it.op = OP_TABLE_WRITE;
    if ($urandom_range(9) != 0) begin
      it.rec_type = TYPE_W'(1 + $urandom_range(NT - 1));
      it.lig_type = TYPE_W'(1 + $urandom_range(NT - 1));
    end
    case ($urandom_range(7))
      0: it.energy_word = E_MAX;
      1: it.energy_word = E_MIN;
      default: ;
    endcase
    return it;
  endfunction

  // Mostly near pairs that land among the steps, some far-flung, some on the rails
  function automatic spe_in_t random_pair(int last_odds);
    spe_in_t it;
    int      mode;
    it   = any_item();
    it.op = OP_PAIR;
    mode = $urandom_range(99);
    if (mode < 60) begin
      it.rec_x = COORD_W'(spread(500000));
      it.rec_y = COORD_W'(spread(500000));
      it.rec_z = COORD_W'(spread(500000));
      it.lig_x = it.rec_x + COORD_W'(spread(REACH));
      it.lig_y = it.rec_y + COORD_W'(spread(REACH));
      it.lig_z = it.rec_z + COORD_W'(spread(REACH));
    end else if (mode >= 85) begin
      it.rec_x = rail_coord();
      it.rec_y = rail_coord();
      it.rec_z = rail_coord();
      it.lig_x = rail_coord();
      it.lig_y = rail_coord();
      it.lig_z = rail_coord();
    end
    if ($urandom_range(9) != 0) begin
      it.rec_type = TYPE_W'(1 + $urandom_range(NT - 1));
      it.lig_type = TYPE_W'(1 + $urandom_range(NT - 1));
    end
    it.last_pair = ($urandom_range(last_odds - 1) == 0);
    return it;
  endfunction

  // Offer one item and hold it until taken; idle first unless calm
  task automatic push_item(spe_in_t it);
    while (!calm && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_item  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.take_item(it);
  endtask

  // Send a pair, first filling the table entry it will read if still unwritten
  task automatic send_pair(spe_in_t it);
    spe_in_t fill;
    int      step;
    step = tracker.hit_step(it);
    if (step >= 0 && !tracker.written[tracker.entry_addr(step, it.rec_type, it.lig_type)]) begin
      fill            = any_item();
      fill.op         = OP_TABLE_WRITE;
      fill.step_index = STEP_W'(step);
      fill.rec_type   = it.rec_type;
      fill.lig_type   = it.lig_type;
      push_item(fill);
    end
    push_item(it);
  endtask

  task automatic random_items(int count, int last_odds);
    repeat (count) begin
      if ($urandom_range(99) < 30) push_item(random_write());
      else send_pair(random_pair(last_odds));
    end
  endtask

  // Drop valid, wait for every pending sum, then let the pipe empty of
  // items that produce no result before anything touches the registers
  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write all five registers back to back
  task automatic load_setting(input logic [ACT_W-1:0] steps,
                              input logic [CFG_DATA_W-1:0] l0, l1, l2, l3);
    logic [CFG_DATA_W-1:0] vals [5];
    logic [CFG_IDX_W-1:0]  regs [5];
    int                    k;
    vals = '{CFG_DATA_W'(steps), l0, l1, l2, l3};
    regs = '{REG_ACTIVE_STEPS, REG_LIMIT_0, REG_LIMIT_1, REG_LIMIT_2, REG_LIMIT_3};
    for (k = 0; k < 5; k++) begin
      cfg_index <= regs[k];
      cfg_data  <= vals[k];
      cfg_valid <= 1'b1;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      tracker.set_reg(regs[k], vals[k]);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    spe_in_t probe;
    int      n;
    tracker = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Four steps at 4, 8, 12 and 16 Angstrom
    load_setting(3'd4, sq_radius(4), sq_radius(8), sq_radius(12), sq_radius(16));

    // Table writes at the energy extremes; last_pair on a write must be ignored
    push_item(shaped_item(OP_TABLE_WRITE, 1, 1, 0, E_MAX, 0, 1'b1));
    push_item(shaped_item(OP_TABLE_WRITE, NT, NT, 1, E_MIN, 0, 1'b0));
    push_item(shaped_item(OP_TABLE_WRITE, NT, NT, 0, E_MIN, 0, 1'b0));
    push_item(shaped_item(OP_TABLE_WRITE, 1, NT, 3, E_NEG1, 0, 1'b0));
    push_item(shaped_item(OP_TABLE_WRITE, 5, 7, 2, 32'sd1, 0, 1'b0));
    // Writes with a type of zero or past the table are dropped
    push_item(shaped_item(OP_TABLE_WRITE, 0, 1, 0, E_MIN, 0, 1'b0));
    push_item(shaped_item(OP_TABLE_WRITE, 1, NT + 1, 0, E_MIN, 0, 1'b0));
    push_item(shaped_item(OP_TABLE_WRITE, 63, 63, 3, E_MAX, 0, 1'b0));

    // Pairs: zero distance, mid step, exactly on a limit (falls to the next
    // step), outermost step, both rails apart (no step), bad types (counted
    // but add nothing), then close the list
    send_pair(shaped_item(OP_PAIR, 1, 1, 0, '0, 0, 1'b0));
    send_pair(shaped_item(OP_PAIR, NT, NT, 0, '0, 6 * 1024, 1'b0));
    send_pair(shaped_item(OP_PAIR, NT, NT, 0, '0, 4 * 1024, 1'b0));
    send_pair(shaped_item(OP_PAIR, 1, NT, 0, '0, -15 * 1024, 1'b0));
    probe       = shaped_item(OP_PAIR, 1, 1, 0, '0, 0, 1'b0);
    probe.rec_x = COORD_MIN;
    probe.rec_y = COORD_MIN;
    probe.rec_z = COORD_MIN;
    probe.lig_x = COORD_MAX;
    probe.lig_y = COORD_MAX;
    probe.lig_z = COORD_MAX;
    send_pair(probe);
    send_pair(shaped_item(OP_PAIR, 0, 1, 0, '0, 0, 1'b0));
    send_pair(shaped_item(OP_PAIR, 63, 1, 0, '0, 0, 1'b0));
    send_pair(shaped_item(OP_PAIR, 1, NT + 1, 0, '0, 0, 1'b1));
    // A list of a single pair
    send_pair(shaped_item(OP_PAIR, 1, 1, 0, '0, 0, 1'b1));

    // Large positive sum at full rate with no idling on either side; a few
    // negative energies then pull the sum back down
    calm <= 1'b1;
    for (n = 0; n < BIG_PAIRS; n++) send_pair(shaped_item(OP_PAIR, 1, 1, 0, '0, 0, 1'b0));
    repeat (2) send_pair(shaped_item(OP_PAIR, NT, NT, 0, '0, 0, 1'b0));
    send_pair(shaped_item(OP_PAIR, NT, NT, 0, '0, 0, 1'b1));
    calm <= 1'b0;

    // Large negative sum, then a short list
    for (n = 0; n < BIG_PAIRS; n++) send_pair(shaped_item(OP_PAIR, NT, NT, 0, '0, 0, 1'b0));
    send_pair(shaped_item(OP_PAIR, NT, NT, 0, '0, 0, 1'b1));
    send_pair(shaped_item(OP_PAIR, 1, 1, 0, '0, 0, 1'b1));

    random_items(PHASE_ITEMS, 8);

    // Two steps; short lists while the receiver holds off for a long stretch
    settle();
    load_setting(3'd2, sq_radius(6), sq_radius(10), LIMIT_TOP, LIMIT_TOP);
    hold_req <= 1'b1;
    random_items(PHASE_ITEMS, 3);

    // Step count above the limit registers clamps to four
    settle();
    load_setting(3'd7, sq_radius(3), sq_radius(6), sq_radius(9), LIMIT_TOP);
    random_items(PHASE_ITEMS, 8);

    // No steps: every pair counts and adds nothing
    settle();
    load_setting(3'd0, any_limit(), any_limit(), any_limit(), any_limit());
    random_items(PHASE_ITEMS, 8);

    // Zero limits: nothing is strictly below them
    settle();
    load_setting(3'd4, '0, '0, '0, '0);
    random_items(PHASE_ITEMS, 8);

    // Largest limit: every well-typed pair reads step zero
    settle();
    load_setting(3'd1, LIMIT_TOP, any_limit(), any_limit(), any_limit());
    random_items(PHASE_ITEMS, 8);

    // Limits out of order: the first one above the distance wins
    settle();
    load_setting(3'd4, sq_radius(16), sq_radius(4), sq_radius(20), sq_radius(8));
    random_items(PHASE_ITEMS, 8);

    settle();
    load_setting(3'd3, sq_radius($urandom_range(20, 1)), sq_radius($urandom_range(20, 1)),
                 sq_radius($urandom_range(20, 1)), sq_radius($urandom_range(20, 1)));
    random_items(PHASE_ITEMS, 8);

    settle();
    if (tracker.errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
